/* hw/rtl/frad_pkg.sv */
// ============================================================================
// frad_pkg: shared constants, types and ladder table
// Fixed-point widths, item structures and the bitrate ladder used by the
// fuzzy rate adapter pipeline.
// ============================================================================
package frad_pkg;

   // fixed-point and field widths
   localparam int FRAC_BITS   = 16;
   localparam int LADDER_SIZE = 8;
   localparam int LVL_W       = 20;
   localparam int CHG_W       = 21;
   localparam int RATE_W      = 26;
   localparam int TGT_W       = 16;
   localparam int IDX_W       = 3;

   // membership divider: Q1.F quotient, one bit per stage
   localparam int MEM_W       = FRAC_BITS + 1;
   localparam int DIV_STEPS   = MEM_W;
   localparam int REM_W       = TGT_W + 1;

   // root-sum-square: sum of up to three squares, two radicand bits per stage
   localparam int SQ_W        = 2 * MEM_W;
   localparam int ROOT_W      = MEM_W;
   localparam int ROOT_STEPS  = SQ_W / 2;
   localparam int SQR_REM_W   = ROOT_W + 3;

   // factor divider: Q3.F quotient
   localparam int NUM_W       = ROOT_W + 5;
   localparam int DEN_W       = ROOT_W + 3;
   localparam int DVR_W       = DEN_W + 2;
   localparam int FACT_W      = FRAC_BITS + 3;
   localparam int FACT_STEPS  = FACT_W;
   localparam int NLO_W       = FACT_W - FRAC_BITS;
   localparam int PROD_W      = FACT_W + RATE_W;
   localparam int SRATE_W     = PROD_W - FRAC_BITS;
   localparam int SEL_W       = $clog2(LADDER_SIZE);

   localparam logic [MEM_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // base ladder, entries past the last repeat the top value
   localparam int LADDER_BASE = 8;
   localparam logic [RATE_W-1:0] LADDER_TAB [0:LADDER_BASE-1] = '{
      26'd3128000, 26'd3254000, 26'd3974000, 26'd4496000,
      26'd6408000, 26'd10938000, 26'd17156000, 26'd35018000
   };

   typedef enum logic [1:0] {
      LVL_EMPTY, LVL_LOW, LVL_HIGH, LVL_FULL
   } lvl_class_type;

   typedef enum logic [1:0] {
      CHG_FALL_ALL, CHG_FALL, CHG_RISE, CHG_RISE_ALL
   } chg_class_type;

   typedef struct packed {
      logic [MEM_W-1:0] empty;
      logic [MEM_W-1:0] ok;
      logic [MEM_W-1:0] full;
      logic [MEM_W-1:0] falling;
      logic [MEM_W-1:0] steady;
      logic [MEM_W-1:0] rising;
   } member_type;

   typedef struct packed {
      logic [ROOT_W-1:0] cr;
      logic [ROOT_W-1:0] csr;
      logic [ROOT_W-1:0] cnc;
      logic [ROOT_W-1:0] csi;
      logic [ROOT_W-1:0] ci;
   } class_type;

   function automatic logic [RATE_W-1:0] ladder_at(input int unsigned i);
      logic [RATE_W-1:0] val;
      if (i < LADDER_BASE) val = LADDER_TAB[i[2:0]];
      else val = LADDER_TAB[LADDER_BASE-1];
      return val;
   endfunction

endpackage

/* hw/rtl/frad_member.sv */
// ============================================================================
// frad_member: membership grading
// Classifies level and change, runs two restoring ratio dividers (one
// quotient bit per stage) and forms the six triangular memberships.
// ============================================================================
module frad_member (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [frad_pkg::LVL_W-1:0]         lvl,
   input  logic signed [frad_pkg::CHG_W-1:0]  chg,
   input  logic [frad_pkg::RATE_W-1:0]        prev,
   input  logic [frad_pkg::TGT_W-1:0]         target,
   output logic                               out_valid,
   output frad_pkg::member_type               mem,
   output logic [frad_pkg::RATE_W-1:0]        out_prev
);

   localparam int LW = frad_pkg::LVL_W;
   localparam int CW = frad_pkg::CHG_W;
   localparam int TW = frad_pkg::TGT_W;
   localparam int RW = frad_pkg::REM_W;
   localparam int NS = frad_pkg::DIV_STEPS;
   localparam int MW = frad_pkg::MEM_W;
   localparam int EW = MW + 2;

   typedef struct packed {
      frad_pkg::lvl_class_type   lcl;
      frad_pkg::chg_class_type   ccl;
      logic [RW-1:0]             rem_l;
      logic [RW-1:0]             rem_c;
      logic [NS-1:0]             quo_l;
      logic [NS-1:0]             quo_c;
      logic [frad_pkg::RATE_W-1:0] prev;
   } mstage_type;

   mstage_type            st_ff [0:NS];
   mstage_type            st_in [0:NS];
   logic [NS:0]           vld_ff;
   logic [CW-1:0]         chg_u;
   logic                  chg_neg;
   logic [CW-1:0]         chg_mag;
   logic [RW-1:0]         tgt_r;
   frad_pkg::member_type  mem_in;
   frad_pkg::member_type  mem_ff;
   logic                  vo_ff;
   logic [frad_pkg::RATE_W-1:0] prev_ff;

   assign chg_u = chg;
   assign tgt_r = RW'(target);

   // entry: magnitude of change, region of level and change
   always_comb begin
      st_in[0] = '0;
      st_in[0].prev = prev;
      chg_neg = chg_u[CW-1];
      chg_mag = chg_neg ? (~chg_u + CW'(1)) : chg_u;
      if (lvl == '0) begin
         st_in[0].lcl = frad_pkg::LVL_EMPTY;
      end else if (lvl < LW'(target)) begin
         st_in[0].lcl   = frad_pkg::LVL_LOW;
         st_in[0].rem_l = RW'(lvl);
      end else if (lvl < LW'({target, 1'b0})) begin
         st_in[0].lcl   = frad_pkg::LVL_HIGH;
         st_in[0].rem_l = RW'(lvl - LW'(target));
      end else begin
         st_in[0].lcl = frad_pkg::LVL_FULL;
      end
      if (chg_neg && (chg_mag > CW'(target))) begin
         st_in[0].ccl = frad_pkg::CHG_FALL_ALL;
      end else if (chg_neg) begin
         st_in[0].ccl   = frad_pkg::CHG_FALL;
         st_in[0].rem_c = RW'(chg_mag);
      end else if (chg_mag < CW'(target)) begin
         st_in[0].ccl   = frad_pkg::CHG_RISE;
         st_in[0].rem_c = RW'(chg_mag);
      end else begin
         st_in[0].ccl = frad_pkg::CHG_RISE_ALL;
      end
   end

   // divider stages: first stage tests the integer bit, later ones shift
   for (genvar j = 0; j < NS; j++) begin : g_step
      logic [RW-1:0] rin_l;
      logic [RW-1:0] rin_c;
      logic          ge_l;
      logic          ge_c;
      always_comb begin
         st_in[j+1] = st_ff[j];
         rin_l = (j == 0) ? st_ff[j].rem_l : {st_ff[j].rem_l[TW-1:0], 1'b0};
         rin_c = (j == 0) ? st_ff[j].rem_c : {st_ff[j].rem_c[TW-1:0], 1'b0};
         ge_l  = (rin_l >= tgt_r);
         ge_c  = (rin_c >= tgt_r);
         st_in[j+1].rem_l = ge_l ? (rin_l - tgt_r) : rin_l;
         st_in[j+1].rem_c = ge_c ? (rin_c - tgt_r) : rin_c;
         st_in[j+1].quo_l = {st_ff[j].quo_l[NS-2:0], ge_l};
         st_in[j+1].quo_c = {st_ff[j].quo_c[NS-2:0], ge_c};
      end
   end

   // memberships from the ratios; each pair sums to one
   always_comb begin
      mem_in = '0;
      case (st_ff[NS].lcl)
         frad_pkg::LVL_EMPTY: mem_in.empty = frad_pkg::ONE;
         frad_pkg::LVL_LOW: begin
            mem_in.ok    = st_ff[NS].quo_l;
            mem_in.empty = frad_pkg::ONE - st_ff[NS].quo_l;
         end
         frad_pkg::LVL_HIGH: begin
            mem_in.full = st_ff[NS].quo_l;
            mem_in.ok   = frad_pkg::ONE - st_ff[NS].quo_l;
         end
         default: mem_in.full = frad_pkg::ONE;
      endcase
      case (st_ff[NS].ccl)
         frad_pkg::CHG_FALL_ALL: mem_in.falling = frad_pkg::ONE;
         frad_pkg::CHG_FALL: begin
            mem_in.falling = st_ff[NS].quo_c;
            mem_in.steady  = frad_pkg::ONE - st_ff[NS].quo_c;
         end
         frad_pkg::CHG_RISE: begin
            mem_in.rising = st_ff[NS].quo_c;
            mem_in.steady = frad_pkg::ONE - st_ff[NS].quo_c;
         end
         default: mem_in.rising = frad_pkg::ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         vo_ff  <= 1'b0;
      end else begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
         vo_ff  <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      mem_ff  <= mem_in;
      prev_ff <= st_ff[NS].prev;
   end

   assign out_valid = vo_ff;
   assign mem       = mem_ff;
   assign out_prev  = prev_ff;

   a_level_sum: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (EW'(mem_ff.empty) + EW'(mem_ff.ok) + EW'(mem_ff.full))
                == EW'(frad_pkg::ONE))
      else $error("level memberships do not sum to one");

   a_change_sum: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (EW'(mem_ff.falling) + EW'(mem_ff.steady) + EW'(mem_ff.rising))
                == EW'(frad_pkg::ONE))
      else $error("change memberships do not sum to one");

endmodule

/* hw/rtl/frad_isqrt.sv */
// ============================================================================
// frad_isqrt: pipelined integer square root
// Digit-by-digit floor root, two radicand bits per register stage.
// ============================================================================
module frad_isqrt (
   input  logic                            clock,
   input  logic [frad_pkg::SQ_W-1:0]       rad,
   output logic [frad_pkg::ROOT_W-1:0]     root
);

   localparam int SW = frad_pkg::SQ_W;
   localparam int QW = frad_pkg::ROOT_W;
   localparam int RW = frad_pkg::SQR_REM_W;
   localparam int NS = frad_pkg::ROOT_STEPS;

   logic [SW-1:0] rad_ff  [0:NS-1];
   logic [SW-1:0] rad_in  [0:NS-1];
   logic [RW-1:0] rem_ff  [0:NS-1];
   logic [RW-1:0] rem_in  [0:NS-1];
   logic [QW-1:0] root_ff [0:NS-1];
   logic [QW-1:0] root_in [0:NS-1];

   for (genvar j = 0; j < NS; j++) begin : g_step
      logic [SW-1:0]   rad_s;
      logic [RW-1:0]   rem_s;
      logic [QW-1:0]   root_s;
      logic [RW+1:0]   rin;
      logic [RW+1:0]   trial;
      logic            take;
      if (j == 0) begin : g_first
         assign rad_s  = rad;
         assign rem_s  = '0;
         assign root_s = '0;
      end else begin : g_next
         assign rad_s  = rad_ff[j-1];
         assign rem_s  = rem_ff[j-1];
         assign root_s = root_ff[j-1];
      end
      // trial subtract of 4*root + 1
      always_comb begin
         rin        = {rem_s, rad_s[SW-1 -: 2]};
         trial      = (RW+2)'({root_s, 2'b01});
         take       = (rin >= trial);
         rem_in[j]  = take ? RW'(rin - trial) : RW'(rin);
         root_in[j] = {root_s[QW-2:0], take};
         rad_in[j]  = rad_s << 2;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff[NS-1];

endmodule

/* hw/rtl/frad_classes.sv */
// ============================================================================
// frad_classes: rule evaluation and class merge
// Nine min-rules, squares, sums and three root units give the five classes.
// ============================================================================
module frad_classes (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  frad_pkg::member_type          mem,
   input  logic [frad_pkg::RATE_W-1:0]   in_prev,
   output logic                          out_valid,
   output frad_pkg::class_type           cls,
   output logic [frad_pkg::RATE_W-1:0]   out_prev
);

   localparam int MW = frad_pkg::MEM_W;
   localparam int SW = frad_pkg::SQ_W;
   localparam int NS = frad_pkg::ROOT_STEPS;
   localparam int LAT = NS + 3;

   typedef struct packed {
      logic [MW-1:0]               cr;
      logic [MW-1:0]               ci;
      logic [frad_pkg::RATE_W-1:0] prev;
   } side_type;

   logic [LAT-1:0] vld_ff;
   logic [MW-1:0]  rule_ff [0:8];
   logic [MW-1:0]  rule_in [0:8];
   logic [SW-1:0]  sq_ff   [1:7];
   logic [SW-1:0]  sum_ff  [0:2];
   side_type       s1_ff, s2_ff, s3_ff;
   side_type       line_ff [0:NS-1];
   logic [frad_pkg::ROOT_W-1:0] root_sr, root_nc, root_si;

   // min-rules: level by change
   always_comb begin
      rule_in[0] = (mem.full  < mem.rising)  ? mem.full  : mem.rising;
      rule_in[1] = (mem.ok    < mem.rising)  ? mem.ok    : mem.rising;
      rule_in[2] = (mem.empty < mem.rising)  ? mem.empty : mem.rising;
      rule_in[3] = (mem.full  < mem.steady)  ? mem.full  : mem.steady;
      rule_in[4] = (mem.ok    < mem.steady)  ? mem.ok    : mem.steady;
      rule_in[5] = (mem.empty < mem.steady)  ? mem.empty : mem.steady;
      rule_in[6] = (mem.full  < mem.falling) ? mem.full  : mem.falling;
      rule_in[7] = (mem.ok    < mem.falling) ? mem.ok    : mem.falling;
      rule_in[8] = (mem.empty < mem.falling) ? mem.empty : mem.falling;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], in_valid};
   end

   // rule, square and sum stages
   always_ff @(posedge clock) begin
      rule_ff <= rule_in;
      s1_ff   <= '{cr: rule_in[0], ci: rule_in[8], prev: in_prev};
      for (int i = 1; i <= 7; i++) begin
         sq_ff[i] <= rule_ff[i] * rule_ff[i];
      end
      s2_ff     <= s1_ff;
      sum_ff[0] <= sq_ff[1] + sq_ff[3];
      sum_ff[1] <= SW'(sq_ff[2] + sq_ff[4] + sq_ff[6]);
      sum_ff[2] <= sq_ff[5] + sq_ff[7];
      s3_ff     <= s2_ff;
   end

   frad_isqrt u_sqrt_sr (.clock(clock), .rad(sum_ff[0]), .root(root_sr));
   frad_isqrt u_sqrt_nc (.clock(clock), .rad(sum_ff[1]), .root(root_nc));
   frad_isqrt u_sqrt_si (.clock(clock), .rad(sum_ff[2]), .root(root_si));

   // side data waits alongside the root units
   always_ff @(posedge clock) begin
      line_ff[0] <= s3_ff;
      for (int i = 1; i < NS; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_prev  = line_ff[NS-1].prev;
   assign cls       = '{cr: line_ff[NS-1].cr, csr: root_sr, cnc: root_nc,
                        csi: root_si, ci: line_ff[NS-1].ci};

endmodule

/* hw/rtl/frad_factor.sv */
// ============================================================================
// frad_factor: weighted factor, rate scaling and ladder choice
// Weighted sum over class sum through a restoring divider, one quotient bit
// per stage, then the rate multiply and the ladder search.
// ============================================================================
module frad_factor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  frad_pkg::class_type           cls,
   input  logic [frad_pkg::RATE_W-1:0]   prev,
   output logic                          out_valid,
   output logic [frad_pkg::RATE_W-1:0]   chosen_rate,
   output logic [frad_pkg::IDX_W-1:0]    chosen_index
);

   localparam int NW = frad_pkg::NUM_W;
   localparam int DW = frad_pkg::DEN_W;
   localparam int VW = frad_pkg::DVR_W;
   localparam int FW = frad_pkg::FACT_W;
   localparam int NS = frad_pkg::FACT_STEPS;
   localparam int FB = frad_pkg::FRAC_BITS;
   localparam int PW = frad_pkg::PROD_W;
   localparam int QW = frad_pkg::SRATE_W;
   localparam int XW = frad_pkg::SEL_W;

   typedef struct packed {
      logic [VW-1:0]                rem;
      logic [VW-1:0]                dvr;
      logic [FW-1:0]                quo;
      logic [frad_pkg::NLO_W-1:0]   nlo;
      logic                         dz;
      logic [frad_pkg::RATE_W-1:0]  prev;
   } fstage_type;

   fstage_type           st_ff [0:NS];
   fstage_type           st_in [0:NS];
   logic [NS+2:0]        vld_ff;
   logic [NW-1:0]        num;
   logic [DW-1:0]        den;
   logic [FW-1:0]        factor;
   logic [PW-1:0]        prod_ff;
   logic [QW-1:0]        srate;
   logic [XW-1:0]        sel;
   logic [frad_pkg::RATE_W-1:0] rate_ff;
   logic [frad_pkg::IDX_W-1:0]  idx_ff;

   // weighted sum (weights times four) and class sum
   always_comb begin
      num = NW'(cls.cr) + (NW'(cls.csr) << 1) + (NW'(cls.cnc) << 2)
          + (NW'(cls.csi) << 3) + (NW'(cls.ci) << 4);
      den = DW'(cls.cr) + DW'(cls.csr) + DW'(cls.cnc) + DW'(cls.csi) + DW'(cls.ci);
      st_in[0]      = '0;
      st_in[0].rem  = VW'(num >> frad_pkg::NLO_W);
      st_in[0].dvr  = {den, 2'b00};
      st_in[0].nlo  = num[frad_pkg::NLO_W-1:0];
      st_in[0].dz   = (den == '0);
      st_in[0].prev = prev;
   end

   // divider stages, dividend bits below the fraction point are zero
   for (genvar s = 0; s < NS; s++) begin : g_step
      localparam int K = NS - 1 - s;
      logic          nb;
      logic [VW:0]   rin;
      logic          ge;
      if (K >= FB) begin : g_bit
         assign nb = st_ff[s].nlo[K-FB];
      end else begin : g_zero
         assign nb = 1'b0;
      end
      always_comb begin
         st_in[s+1]     = st_ff[s];
         rin            = {st_ff[s].rem, nb};
         ge             = (rin >= (VW+1)'(st_ff[s].dvr));
         st_in[s+1].rem = ge ? VW'(rin - (VW+1)'(st_ff[s].dvr)) : VW'(rin);
         st_in[s+1].quo = {st_ff[s].quo[FW-2:0], ge};
      end
   end

   assign factor = st_ff[NS].dz ? FW'(frad_pkg::ONE) : st_ff[NS].quo;
   assign srate  = prod_ff[PW-1:FB];

   // ladder: entry below the first one that exceeds the scaled rate
   always_comb begin
      sel = XW'(frad_pkg::LADDER_SIZE - 1);
      for (int i = frad_pkg::LADDER_SIZE - 1; i >= 1; i--) begin
         if (QW'(frad_pkg::ladder_at(i)) > srate) sel = XW'(i - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[NS+1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      prod_ff <= PW'(factor) * PW'(st_ff[NS].prev);
      rate_ff <= frad_pkg::ladder_at(int'(sel));
      idx_ff  <= frad_pkg::IDX_W'(sel);
   end

   assign out_valid    = vld_ff[NS+2];
   assign chosen_rate  = rate_ff;
   assign chosen_index = idx_ff;

   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS] && !st_ff[NS].dz |->
         (st_ff[NS].quo >= FW'(frad_pkg::ONE >> 2))
         && (st_ff[NS].quo <= (FW'(frad_pkg::ONE) << 2)))
      else $error("factor outside a quarter to four");

endmodule

/* hw/rtl/fuzzy_rate_adapter.sv */
// ============================================================================
// fuzzy_rate_adapter: fuzzy-logic bitrate choice
// Grades buffer level and change, merges nine rules into five classes,
// forms a rate factor and picks the bitrate ladder entry.
// ============================================================================
//  channel   ports                         handshake
//  request   req_buffer_level/_change,     start, accepted when busy is low
//            req_previous_rate
//  response  rsp_chosen_rate/_index        rsp_valid, one-cycle strobe
//  control   csr_wr_data                   csr_wr_en, written at once
//
//  One item per cycle; busy stays low. Items pass through the
//  membership dividers, the rule merge (17 root stages), then the
//  factor divider, multiply and ladder search.
//  Synchronous reset clears all valid bits and sets target_level to 2000.
//  The receiver cannot stall; results leave on the strobe cycle.
module fuzzy_rate_adapter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [frad_pkg::LVL_W-1:0]         req_buffer_level,
   input  logic signed [frad_pkg::CHG_W-1:0]  req_buffer_change,
   input  logic [frad_pkg::RATE_W-1:0]        req_previous_rate,
   output logic                               rsp_valid,
   output logic [frad_pkg::RATE_W-1:0]        rsp_chosen_rate,
   output logic [frad_pkg::IDX_W-1:0]         rsp_chosen_index,
   input  logic                               csr_wr_en,
   input  logic [frad_pkg::TGT_W-1:0]         csr_wr_data
);

   logic [frad_pkg::TGT_W-1:0]  target_ff;
   logic                        mem_valid;
   frad_pkg::member_type        mem;
   logic [frad_pkg::RATE_W-1:0] mem_prev;
   logic                        cls_valid;
   frad_pkg::class_type         cls;
   logic [frad_pkg::RATE_W-1:0] cls_prev;

   // target level register
   always_ff @(posedge clock) begin
      if (reset) target_ff <= frad_pkg::TGT_W'(2000);
      else if (csr_wr_en) target_ff <= csr_wr_data;
   end

   assign busy = 1'b0;

   frad_member u_member (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .lvl       (req_buffer_level),
      .chg       (req_buffer_change),
      .prev      (req_previous_rate),
      .target    (target_ff),
      .out_valid (mem_valid),
      .mem       (mem),
      .out_prev  (mem_prev)
   );

   frad_classes u_classes (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mem_valid),
      .mem       (mem),
      .in_prev   (mem_prev),
      .out_valid (cls_valid),
      .cls       (cls),
      .out_prev  (cls_prev)
   );

   frad_factor u_factor (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (cls_valid),
      .cls          (cls),
      .prev         (cls_prev),
      .out_valid    (rsp_valid),
      .chosen_rate  (rsp_chosen_rate),
      .chosen_index (rsp_chosen_index)
   );

   a_rate_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chosen_rate == frad_pkg::ladder_at(int'(rsp_chosen_index)))
      else $error("chosen rate does not match ladder index");

endmodule

/* dv/fuzzy_rate_adapter_tb.sv */
// ============================================================================
// fuzzy_rate_adapter_tb: self-checking bench for the fuzzy rate adapter
// Drives buffer level, change and previous rate items and predicts each
// chosen ladder entry in-bench. Every result strobe is checked field by field
// against the oldest prediction. The run covers several target levels,
// field extremes and random traffic under varying sender gaps.
// ============================================================================
module fuzzy_rate_adapter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 70;
   localparam int STALL_LIMIT  = 5000;

   typedef struct {
      logic [frad_pkg::RATE_W-1:0] rate;
      logic [frad_pkg::IDX_W-1:0]  index;
   } choice_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [frad_pkg::LVL_W-1:0]          req_buffer_level  = '0;
   logic signed [frad_pkg::CHG_W-1:0]   req_buffer_change = '0;
   logic [frad_pkg::RATE_W-1:0]         req_previous_rate = '0;
   logic                                rsp_valid;
   logic [frad_pkg::RATE_W-1:0]         rsp_chosen_rate;
   logic [frad_pkg::IDX_W-1:0]          rsp_chosen_index;
   logic                                csr_wr_en   = 1'b0;
   logic [frad_pkg::TGT_W-1:0]          csr_wr_data = '0;

   choice_type    pending_choices[$];
   bit [15:0]     target_copy = 16'd2000;
   int            error_count = 0;
   int            stall_cycles = 0;

   fuzzy_rate_adapter dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_buffer_level(req_buffer_level), .req_buffer_change(req_buffer_change),
      .req_previous_rate(req_previous_rate), .rsp_valid(rsp_valid),
      .rsp_chosen_rate(rsp_chosen_rate), .rsp_chosen_index(rsp_chosen_index),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor integer square root
   function automatic bit [63:0] int_root(input bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic bit [63:0] frac_of(input bit [63:0] x, input bit [63:0] t);
      return (t == 0) ? 64'd0 : (x << frad_pkg::FRAC_BITS) / t;
   endfunction

   function automatic bit [63:0] min_of(input bit [63:0] a, input bit [63:0] b);
      return (a < b) ? a : b;
   endfunction

   // expected ladder choice for one item
   function automatic choice_type pick_rate(input bit [19:0] lvl, input bit [20:0] chg,
                                            input bit [25:0] prev, input bit [15:0] tgt);
      bit [63:0]  one, t, mag, emp, okm, ful, fal, sty, ris;
      bit [63:0]  r1, r2, r3, r4, r5, r6, r7, r8, r9;
      bit [63:0]  cr, csr, cnc, csi, ci, num, den, factor, scaled;
      bit         neg;
      int         idx;
      choice_type c;
      one = 64'd1 << frad_pkg::FRAC_BITS;
      t = tgt;
      neg = chg[20];
      mag = neg ? 64'(21'(-chg)) : 64'(chg);
      {emp, okm, ful, fal, sty, ris} = '0;
      // level grading
      if (lvl == 0) emp = one;
      else if (lvl < t) begin
         okm = frac_of(lvl, t);
         emp = one - okm;
      end else if (lvl < 2 * t) begin
         ful = frac_of(lvl - t, t);
         okm = one - ful;
      end else ful = one;
      // change grading
      if (neg && mag > t) fal = one;
      else if (neg) begin
         fal = frac_of(mag, t);
         sty = one - fal;
      end else if (mag < t) begin
         ris = frac_of(mag, t);
         sty = one - ris;
      end else ris = one;
      r1 = min_of(ful, ris); r2 = min_of(okm, ris); r3 = min_of(emp, ris);
      r4 = min_of(ful, sty); r5 = min_of(okm, sty); r6 = min_of(emp, sty);
      r7 = min_of(ful, fal); r8 = min_of(okm, fal); r9 = min_of(emp, fal);
      cr  = r1;
      csr = int_root(r2 * r2 + r4 * r4);
      cnc = int_root(r3 * r3 + r5 * r5 + r7 * r7);
      csi = int_root(r6 * r6 + r8 * r8);
      ci  = r9;
      num = cr + csr * 2 + cnc * 4 + csi * 8 + ci * 16;
      den = cr + csr + cnc + csi + ci;
      factor = (den == 0) ? one : (num << frad_pkg::FRAC_BITS) / (4 * den);
      scaled = (factor * prev) >> frad_pkg::FRAC_BITS;
      idx = frad_pkg::LADDER_SIZE - 1;
      for (int i = frad_pkg::LADDER_SIZE - 1; i >= 1; i--)
         if (frad_pkg::ladder_at(i) > scaled) idx = i - 1;
      c.rate = frad_pkg::ladder_at(idx);
      c.index = idx[frad_pkg::IDX_W-1:0];
      return c;
   endfunction

   // prediction on accept, check on result strobe, register copy
   always @(posedge clock) begin
      choice_type exp_c;
      if (!reset) begin
         if (start && !busy)
            pending_choices.push_back(pick_rate(req_buffer_level, req_buffer_change,
                                                req_previous_rate, target_copy));
         if (rsp_valid) begin
            if (pending_choices.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result rate %0d index %0d", $time,
                        rsp_chosen_rate, rsp_chosen_index);
            end else begin
               exp_c = pending_choices.pop_front();
               if (rsp_chosen_rate !== exp_c.rate) begin
                  error_count++;
                  $display("%0t: chosen_rate expected %0d actual %0d", $time,
                           exp_c.rate, rsp_chosen_rate);
               end
               if (rsp_chosen_index !== exp_c.index) begin
                  error_count++;
                  $display("%0t: chosen_index expected %0d actual %0d", $time,
                           exp_c.index, rsp_chosen_index);
               end
            end
         end
         if (csr_wr_en) target_copy = csr_wr_data;
      end
   end

   // watchdog: cycles with neither an accepted item nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("fuzzy_rate_adapter test failed");
         $finish;
      end
   end

   // present one item and hold it until accepted; called at a rising edge
   task automatic send_item(input bit [19:0] lvl, input bit [20:0] chg,
                            input bit [25:0] prev);
      start <= 1'b1;
      req_buffer_level  <= lvl;
      req_buffer_change <= chg;
      req_previous_rate <= prev;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // idle cycle by cycle while a random draw out of a hundred falls below pct
   task automatic maybe_idle(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending, let every result arrive, then write the target
   task automatic set_target(input bit [15:0] val);
      start <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // grading boundaries around the current target
   task automatic test_boundaries(input bit [15:0] t);
      int unsigned tt;
      tt = t;
      send_item(20'd0, 21'd0, 26'd4000000);
      send_item(20'd1, 21'(-1), 26'h3FFFFFF);
      send_item(20'(tt - 1), 21'(tt - 1), 26'd0);
      send_item(20'(tt), 21'(tt), 26'd3128000);
      send_item(20'(2 * tt - 1), 21'(-int'(tt)), 26'd35018000);
      send_item(20'(2 * tt), 21'(-int'(tt) - 1), 26'd10000000);
      send_item(20'hFFFFF, 21'h0FFFFF, 26'h3FFFFFF);
      send_item(20'(tt / 2), 21'h100000, 26'd6408000);
   endtask

   task automatic test_default_target();
      test_boundaries(16'd2000);
   endtask

   task automatic test_target_extremes();
      set_target(16'd0);
      test_boundaries(16'd0);
      set_target(16'd1);
      test_boundaries(16'd1);
      set_target(16'hFFFF);
      test_boundaries(16'hFFFF);
   endtask

   // mostly items in and just past the graded region, some across the full field range
   task automatic test_random(input int items, input int gap_pct);
      bit [15:0] t;
      int unsigned lvl;
      int chg;
      for (int n = 0; n < items; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(5))
               0: t = 16'd1;
               1: t = 16'hFFFF;
               2: t = 16'($urandom_range(1, 64));
               default: t = 16'($urandom_range(1, 65535));
            endcase
            set_target(t);
         end
         maybe_idle(gap_pct);
         if ($urandom_range(9) < 8) begin
            lvl = $urandom_range(0, 3 * t);
            if (lvl > 20'hFFFFF) lvl = 20'hFFFFF;
            chg = int'($urandom_range(0, 4 * t + 2)) - int'(2 * t + 1);
            send_item(20'(lvl), 21'(chg), 26'($urandom_range(0, 45000000)));
         end else begin
            send_item(20'($urandom), 21'($urandom), 26'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_target();
      test_target_extremes();
      test_random(600, 21);
      test_random(600, 80);
      test_random(600, 0);
      start <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("fuzzy_rate_adapter test passed");
      else $display("fuzzy_rate_adapter test failed");
      $finish;
   end

endmodule
